// File: hw/rtl/archive_crc32_and_byte_scrambler_assert.svh
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: assertion macros
// Concurrent assertion forms used by the RTL core module.
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_CRC32_AND_BYTE_SCRAMBLER_ASSERT_SVH
`define ARCHIVE_CRC32_AND_BYTE_SCRAMBLER_ASSERT_SVH

// check a property outside of reset
`define ACS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acs assertion failed");

// check a property on every edge, reset included
`define ACS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("acs assertion failed");

`endif

// File: hw/rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: package
// Beat types, configuration codes, constants and the CRC byte table.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NAME_MODE = 1'b0,
    CFG_START_ODD = 1'b1
  } cfg_idx_e;

  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [31:0] NameInit     = 32'hFFFF_FFFF;
  localparam logic [31:0] DataFinalXor = 32'h61EA_4E00;
  localparam logic [7:0]  KeyEven      = 8'hAF;
  localparam logic [7:0]  KeyOdd       = 8'h66;
  localparam logic [7:0]  UpperFirst   = 8'h41;
  localparam logic [7:0]  UpperLast    = 8'h5A;
  localparam logic [7:0]  CaseOffset   = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        crc_valid;
    logic [31:0] crc_value;
  } out_beat_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } stage_t;

  typedef logic [31:0] crc_lut_t [256];

  function automatic crc_lut_t crc_lut_gen();
    crc_lut_t    lut;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      lut[i] = c;
    end
    return lut;
  endfunction

  localparam crc_lut_t CrcLut = crc_lut_gen();

endpackage

// File: hw/rtl/acs_in_stage.sv
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: input stage
// Registers each accepted input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module acs_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  acs_pkg::in_beat_t in_data_i,
  input  logic              ready_i,
  output acs_pkg::stage_t   stage_o
);

  logic              valid_q, valid_d;
  acs_pkg::in_beat_t beat_q;
  logic              load;

  assign in_stall_o = valid_q && !ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

// File: hw/rtl/acs_core.sv
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: core
// One CRC table step per beat, the data-mode scramble, stream state, result register.
// ----------------------------------------------------------------------------
`include "archive_crc32_and_byte_scrambler_assert.svh"

module acs_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                       cfg_data_i,
  input  acs_pkg::stage_t            stage_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output acs_pkg::out_beat_t         out_data_o
);

  logic               name_mode_q, start_odd_q;
  logic [31:0]        crc_q, crc_d;
  logic               pos_q, pos_d;
  logic               at_start_q, at_start_d;
  logic               out_valid_q, out_valid_d;
  acs_pkg::out_beat_t out_q, out_d;

  logic        fire;
  logic [31:0] crc_base;
  logic        pos_base;
  logic [7:0]  in_byte;
  logic [7:0]  crc_byte;
  logic [7:0]  lut_idx;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign fire    = stage_i.valid && ready_o;
  assign in_byte = stage_i.beat.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_mode_q <= 1'b0;
      start_odd_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (acs_pkg::cfg_idx_e'(cfg_idx_i))
        acs_pkg::CFG_NAME_MODE: name_mode_q <= cfg_data_i;
        acs_pkg::CFG_START_ODD: start_odd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    crc_base = at_start_q ? (name_mode_q ? acs_pkg::NameInit : '0) : crc_q;
    pos_base = at_start_q ? start_odd_q : pos_q;

    crc_byte = in_byte;
    if (name_mode_q && in_byte >= acs_pkg::UpperFirst && in_byte <= acs_pkg::UpperLast) begin
      crc_byte = in_byte + acs_pkg::CaseOffset;
    end

    lut_idx = crc_base[7:0] ^ crc_byte;

    crc_d      = crc_q;
    pos_d      = pos_q;
    at_start_d = at_start_q;
    out_d      = out_q;
    if (fire) begin
      crc_d      = (crc_base >> 8) ^ acs_pkg::CrcLut[lut_idx];
      pos_d      = !pos_base;
      at_start_d = stage_i.beat.last_byte;
      out_d.out_byte = name_mode_q ? in_byte
                     : (in_byte ^ (pos_base ? acs_pkg::KeyOdd : acs_pkg::KeyEven));
      out_d.crc_valid = stage_i.beat.last_byte;
      out_d.crc_value = '0;
      if (stage_i.beat.last_byte) begin
        out_d.crc_value = name_mode_q ? crc_d : (crc_d ^ acs_pkg::DataFinalXor);
      end
    end

    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      pos_q       <= 1'b0;
      at_start_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      at_start_q  <= at_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ACS_ASSERT(a_fire_shows_beat, clk_i, rst_ni, fire |=> out_valid_q)
  `ACS_ASSERT(a_last_rearms, clk_i, rst_ni, fire && stage_i.beat.last_byte |=> at_start_q)
  `ACS_ASSERT(a_crc_zero_unless_valid, clk_i, rst_ni,
    out_valid_q && !out_q.crc_valid |-> out_q.crc_value == '0)
  `ACS_ASSERT_ALWAYS(a_no_fire_when_held, clk_i,
    out_valid_q && out_stall_i |-> !fire)

endmodule

// File: hw/rtl/archive_crc32_and_byte_scrambler.sv
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: top level
// Input channel: in_valid_i / in_stall_o with one byte and a last flag a beat.
// Output channel: out_valid_o / out_stall_i, one result beat per input beat:
//   the byte (scrambled in data mode), and on the last beat the finished CRC.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 = name_mode, 1 = start_odd); write only while the block is idle.
// Path: an accepted beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless stalled; the CRC update is one table
//   step on the running checksum register, done in the cycle the core takes it.
// Reset: clears the stream state and both configuration registers; the next
//   beat starts a new stream.
// Stall: a stalled result holds; the input register still takes one beat,
//   after which in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
module archive_crc32_and_byte_scrambler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  acs_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output acs_pkg::out_beat_t          out_data_o
);

  acs_pkg::stage_t stage;
  logic            ready;

  acs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .ready_i    (ready),
    .stage_o    (stage)
  );

  acs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/archive_crc32_and_byte_scrambler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Archive CRC-32 and byte scrambler: testbench
// Streams bytes with last flags through the block in name mode and data mode,
// covering case-folding borders, single-byte streams, register changes between
// streams and in the middle of one, and random idle and stall patterns on both
// channels. Every result beat is checked against a local CRC and scrambler
// predictor, in order, field by field.
// ----------------------------------------------------------------------------
module archive_crc32_and_byte_scrambler_test;

  localparam logic [31:0] Poly       = 32'hEDB8_8320;
  localparam logic [31:0] NameSeed   = 32'hFFFF_FFFF;
  localparam logic [31:0] DataXorOut = 32'h61EA_4E00;
  localparam logic [7:0]  MaskEven   = 8'hAF;
  localparam logic [7:0]  MaskOdd    = 8'h66;
  localparam int unsigned CycleLimit = 200000;
  localparam int          PhaseItems = 92;

  class crc_scrambler_check;
    bit                 name_mode;
    bit                 start_odd;
    logic [31:0]        crc;
    bit                 pos_odd;
    bit                 at_start;
    acs_pkg::out_beat_t due_beats[$];
    int                 fails;

    function new();
      name_mode = 1'b0;
      start_odd = 1'b0;
      crc       = '0;
      pos_odd   = 1'b0;
      at_start  = 1'b1;
      fails     = 0;
    endfunction

    function void set_reg(acs_pkg::cfg_idx_e idx, bit value);
      if (idx == acs_pkg::CFG_NAME_MODE) name_mode = value;
      else start_odd = value;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] d);
      logic [31:0] c;
      c = c_in ^ {24'h0, d};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ Poly) : (c >> 1);
      end
      return c;
    endfunction

    function void take_beat(acs_pkg::in_beat_t b);
      logic [7:0]         folded;
      acs_pkg::out_beat_t e;
      if (at_start) begin
        crc      = name_mode ? NameSeed : 32'h0;
        pos_odd  = start_odd;
        at_start = 1'b0;
      end
      folded     = b.data_byte;
      e.out_byte = b.data_byte;
      if (name_mode) begin
        if (b.data_byte >= 8'h41 && b.data_byte <= 8'h5A) folded = b.data_byte + 8'h20;
      end else begin
        e.out_byte = b.data_byte ^ (pos_odd ? MaskOdd : MaskEven);
      end
      crc         = crc_step(crc, folded);
      pos_odd     = !pos_odd;
      e.crc_valid = b.last_byte;
      e.crc_value = '0;
      if (b.last_byte) begin
        e.crc_value = name_mode ? crc : (crc ^ DataXorOut);
        at_start    = 1'b1;
      end
      due_beats = {due_beats, e};
    endfunction

    function void match_beat(acs_pkg::out_beat_t got);
      acs_pkg::out_beat_t e;
      if (due_beats.size() == 0) begin
        if (fails < 10)
          $display("unexpected beat: out_byte %02h crc_valid %0d crc_value %08h",
                   got.out_byte, got.crc_valid, got.crc_value);
        fails++;
        return;
      end
      e = due_beats.pop_front();
      if (got.out_byte !== e.out_byte || got.crc_valid !== e.crc_valid ||
          got.crc_value !== e.crc_value) begin
        if (fails < 10)
          $display("mismatch: out_byte %02h/%02h crc_valid %0d/%0d crc_value %08h/%08h",
                   e.out_byte, got.out_byte, e.crc_valid, got.crc_valid,
                   e.crc_value, got.crc_value);
        fails++;
      end
    endfunction

    function bit drained();
      return due_beats.size() == 0;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  acs_pkg::cfg_idx_e  cfg_idx = acs_pkg::CFG_NAME_MODE;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  acs_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  acs_pkg::out_beat_t out_data;

  int unsigned        cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  crc_scrambler_check sb;

  archive_crc32_and_byte_scrambler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.match_beat(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] d, input bit last);
    acs_pkg::in_beat_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    b.data_byte = d;
    b.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.take_beat(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (!sb.drained()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input acs_pkg::cfg_idx_e idx, input bit value);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    int         count;
    int         len;
    logic [7:0] b;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: b = 8'($urandom_range(8'h5A, 8'h41));
          1: b = 8'($urandom_range(8'h5C, 8'h3F));
          default: b = 8'($urandom_range(255));
        endcase
        send_beat(b, i == len - 1);
        count++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data mode, even start: no folding, byte extremes, single-byte stream
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h5A, 1'b1);
    send_beat(8'hFF, 1'b1);
    write_reg(acs_pkg::CFG_START_ODD, 1'b1);
    send_beat(8'h12, 1'b0);
    send_beat(8'h80, 1'b1);

    // name mode: fold borders
    write_reg(acs_pkg::CFG_NAME_MODE, 1'b1);
    send_beat(8'h41, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h40, 1'b0);
    send_beat(8'h5B, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h51, 1'b1);

    // switch registers in the middle of a stream
    send_beat(8'h4D, 1'b0);
    send_beat(8'h78, 1'b0);
    write_reg(acs_pkg::CFG_NAME_MODE, 1'b0);
    send_beat(8'h6B, 1'b0);
    send_beat(8'h59, 1'b0);
    write_reg(acs_pkg::CFG_START_ODD, 1'b0);
    send_beat(8'h33, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h02, 1'b1);
    send_beat(8'h5A, 1'b0);
    write_reg(acs_pkg::CFG_NAME_MODE, 1'b1);
    send_beat(8'h41, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(acs_pkg::CFG_NAME_MODE, ph[0]);
      write_reg(acs_pkg::CFG_START_ODD, ph[1] ^ ph[2]);
      case (ph >> 1)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      run_phase(PhaseItems);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.drained())
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
